// ===== sv/icr_pkg.sv =====
// Shared types and fixed-point helpers for the impulse collision response unit.
`default_nettype none
package icr_pkg;

  // Contact lanes built in hardware; icr_front clamps the contact count to MAX_CONTACTS.
  localparam int unsigned LANES = 2;

  typedef logic signed [31:0] s32_t;

  typedef struct packed {
    s32_t x;
    s32_t y;
  } vec_t;

  // Per-collision values that travel alongside the arithmetic.
  typedef struct packed {
    vec_t              pa;
    vec_t              pb;
    vec_t              va;
    vec_t              vb;
    s32_t              wa;
    s32_t              wb;
    logic [31:0]       ima;
    logic [31:0]       imb;
    logic [31:0]       iia;
    logic [31:0]       iib;
    vec_t              n;
    logic [1:0]        cnt;
    vec_t [LANES-1:0]  ra;
    vec_t [LANES-1:0]  rb;
  } ctx_t;

  // Divider operands of one contact lane.
  typedef struct packed {
    logic [31:0] mag;
    logic [63:0] dsor;
    logic        neg;
    logic        act;
  } dv_in_t;

  // Divider result of one contact lane.
  typedef struct packed {
    logic [63:0] quo;
    logic        neg;
    logic        act;
  } dv_out_t;

  function automatic logic signed [32:0] sx(input s32_t a);
    return 33'(a);
  endfunction

  function automatic logic signed [32:0] ux(input logic [31:0] a);
    return $signed({1'b0, a});
  endfunction

  function automatic logic signed [63:0] s64(input s32_t a);
    return 64'(a);
  endfunction

  function automatic s32_t sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return v[31:0];
    end
  endfunction

  // Fixed-point product, rounded to frac fraction bits with halves going up.
  function automatic logic signed [63:0] fmul(input logic signed [32:0] a,
                                              input logic signed [32:0] b,
                                              input int unsigned frac);
    logic signed [65:0] p;
    p = 66'(a) * 66'(b);
    p = p + (66'sd1 <<< (frac - 1));
    p = p >>> frac;
    return p[63:0];
  endfunction

endpackage
`default_nettype wire

// ===== sv/icr_front.sv =====
// Separation of the bodies and per-contact preparation of the impulse division.
`default_nettype none
module icr_front #(
  parameter int FRAC_BITS    = 16,
  parameter int MAX_CONTACTS = 2
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire logic                                    ce,
  input  wire logic                                    in_valid,
  input  wire logic [703:0]                            in_data,
  input  wire logic [3:0]                              in_mode,
  output logic                                         out_valid,
  output icr_pkg::ctx_t                                out_ctx,
  output icr_pkg::dv_in_t [icr_pkg::LANES-1:0]         out_lane
);

  localparam int NST = 11;

  typedef struct packed {
    icr_pkg::vec_t      pra;
    icr_pkg::vec_t      prb;
    logic signed [63:0] mwax;
    logic signed [63:0] mway;
    logic signed [63:0] mwbx;
    logic signed [63:0] mwby;
    logic signed [63:0] dax;
    logic signed [63:0] day;
    logic signed [63:0] dbx;
    logic signed [63:0] dby;
    icr_pkg::vec_t      rel;
    icr_pkg::s32_t      ran;
    icr_pkg::s32_t      rbn;
    logic signed [63:0] e0;
    logic signed [63:0] e1;
    logic signed [63:0] qa;
    logic signed [63:0] qb;
    icr_pkg::s32_t      vn;
    icr_pkg::s32_t      sqa;
    icr_pkg::s32_t      sqb;
    icr_pkg::s32_t      num;
    logic signed [63:0] ta;
    logic signed [63:0] tb;
    logic [31:0]        mag;
    logic [63:0]        dsor;
    logic               neg;
    logic               act;
  } lane_t;

  typedef struct packed {
    icr_pkg::ctx_t                     c;
    icr_pkg::vec_t [icr_pkg::LANES-1:0] cp;
    icr_pkg::s32_t                     depth;
    logic [15:0]                       ea;
    logic [15:0]                       eb;
    logic                              sa;
    logic                              sb;
    icr_pkg::vec_t                     mtv;
    logic signed [32:0]                dx;
    logic signed [32:0]                dy;
    logic signed [65:0]                p1;
    logic signed [65:0]                p2;
    logic [16:0]                       coeff;
    lane_t [icr_pkg::LANES-1:0]        ln;
  } fr_t;

  fr_t s0;
  fr_t nx [1:NST];
  fr_t st [1:NST];
  logic [NST:1] v;

  // Unpack the input word.
  always_comb begin
    s0 = '0;
    s0.c.pa  = icr_pkg::vec_t'(in_data[63:0]);
    s0.c.pb  = icr_pkg::vec_t'(in_data[127:64]);
    s0.c.va  = icr_pkg::vec_t'(in_data[191:128]);
    s0.c.vb  = icr_pkg::vec_t'(in_data[255:192]);
    s0.c.wa  = in_data[319:288];
    s0.c.wb  = in_data[287:256];
    s0.c.ima = in_data[383:352];
    s0.c.imb = in_data[351:320];
    s0.c.iia = in_data[447:416];
    s0.c.iib = in_data[415:384];
    s0.depth = in_data[511:480];
    s0.ea    = in_data[479:464];
    s0.eb    = in_data[463:448];
    s0.c.n   = icr_pkg::vec_t'(in_data[575:512]);
    s0.cp[0] = icr_pkg::vec_t'(in_data[639:576]);
    s0.cp[1] = icr_pkg::vec_t'(in_data[703:640]);
    s0.c.cnt = (in_mode[1:0] > MAX_CONTACTS) ? 2'(MAX_CONTACTS) : in_mode[1:0];
    s0.sa    = in_mode[2];
    s0.sb    = in_mode[3];
  end

  // Penetration vector, position difference and the restitution coefficient.
  always_comb begin
    nx[1] = s0;
    nx[1].mtv.x = icr_pkg::sat32(icr_pkg::fmul(icr_pkg::sx(s0.c.n.x),
                                               icr_pkg::sx(s0.depth), FRAC_BITS));
    nx[1].mtv.y = icr_pkg::sat32(icr_pkg::fmul(icr_pkg::sx(s0.c.n.y),
                                               icr_pkg::sx(s0.depth), FRAC_BITS));
    nx[1].dx = 33'(s0.c.pa.x) - 33'(s0.c.pb.x);
    nx[1].dy = 33'(s0.c.pa.y) - 33'(s0.c.pb.y);
    nx[1].coeff = 17'h10000 + 17'((17'(s0.ea) + 17'(s0.eb)) >> 1);
  end

  always_comb begin
    nx[2] = st[1];
    nx[2].p1 = 66'(st[1].mtv.x) * 66'(st[1].dx);
    nx[2].p2 = 66'(st[1].mtv.y) * 66'(st[1].dy);
  end

  // Turn the vector so that it points from B towards A.
  always_comb begin
    nx[3] = st[2];
    if ((st[2].p1 + st[2].p2) < 66'sd0) begin
      nx[3].mtv.x = icr_pkg::sat32(-icr_pkg::s64(st[2].mtv.x));
      nx[3].mtv.y = icr_pkg::sat32(-icr_pkg::s64(st[2].mtv.y));
    end
  end

  always_comb begin
    icr_pkg::s32_t hx;
    icr_pkg::s32_t hy;
    nx[4] = st[3];
    hx = st[3].mtv.x >>> 1;
    hy = st[3].mtv.y >>> 1;
    if (st[3].sa) begin
      nx[4].c.pb.x = icr_pkg::sat32(icr_pkg::s64(st[3].c.pb.x) - icr_pkg::s64(st[3].mtv.x));
      nx[4].c.pb.y = icr_pkg::sat32(icr_pkg::s64(st[3].c.pb.y) - icr_pkg::s64(st[3].mtv.y));
    end else if (st[3].sb) begin
      nx[4].c.pa.x = icr_pkg::sat32(icr_pkg::s64(st[3].c.pa.x) + icr_pkg::s64(st[3].mtv.x));
      nx[4].c.pa.y = icr_pkg::sat32(icr_pkg::s64(st[3].c.pa.y) + icr_pkg::s64(st[3].mtv.y));
    end else begin
      nx[4].c.pa.x = icr_pkg::sat32(icr_pkg::s64(st[3].c.pa.x) + icr_pkg::s64(hx));
      nx[4].c.pa.y = icr_pkg::sat32(icr_pkg::s64(st[3].c.pa.y) + icr_pkg::s64(hy));
      nx[4].c.pb.x = icr_pkg::sat32(icr_pkg::s64(st[3].c.pb.x) - icr_pkg::s64(hx));
      nx[4].c.pb.y = icr_pkg::sat32(icr_pkg::s64(st[3].c.pb.y) - icr_pkg::s64(hy));
    end
  end

  // Lever arms and their perpendiculars.
  always_comb begin
    nx[5] = st[4];
    for (int i = 0; i < icr_pkg::LANES; i++) begin
      nx[5].c.ra[i].x = icr_pkg::sat32(icr_pkg::s64(st[4].cp[i].x) - icr_pkg::s64(st[4].c.pa.x));
      nx[5].c.ra[i].y = icr_pkg::sat32(icr_pkg::s64(st[4].cp[i].y) - icr_pkg::s64(st[4].c.pa.y));
      nx[5].c.rb[i].x = icr_pkg::sat32(icr_pkg::s64(st[4].cp[i].x) - icr_pkg::s64(st[4].c.pb.x));
      nx[5].c.rb[i].y = icr_pkg::sat32(icr_pkg::s64(st[4].cp[i].y) - icr_pkg::s64(st[4].c.pb.y));
      nx[5].ln[i].pra.x = icr_pkg::sat32(-icr_pkg::s64(nx[5].c.ra[i].y));
      nx[5].ln[i].pra.y = nx[5].c.ra[i].x;
      nx[5].ln[i].prb.x = icr_pkg::sat32(-icr_pkg::s64(nx[5].c.rb[i].y));
      nx[5].ln[i].prb.y = nx[5].c.rb[i].x;
    end
  end

  always_comb begin
    nx[6] = st[5];
    for (int i = 0; i < icr_pkg::LANES; i++) begin
      nx[6].ln[i].mwax = icr_pkg::fmul(icr_pkg::sx(st[5].ln[i].pra.x),
                                       icr_pkg::sx(st[5].c.wa), FRAC_BITS);
      nx[6].ln[i].mway = icr_pkg::fmul(icr_pkg::sx(st[5].ln[i].pra.y),
                                       icr_pkg::sx(st[5].c.wa), FRAC_BITS);
      nx[6].ln[i].mwbx = icr_pkg::fmul(icr_pkg::sx(st[5].ln[i].prb.x),
                                       icr_pkg::sx(st[5].c.wb), FRAC_BITS);
      nx[6].ln[i].mwby = icr_pkg::fmul(icr_pkg::sx(st[5].ln[i].prb.y),
                                       icr_pkg::sx(st[5].c.wb), FRAC_BITS);
      nx[6].ln[i].dax = icr_pkg::fmul(icr_pkg::sx(st[5].ln[i].pra.x),
                                      icr_pkg::sx(st[5].c.n.x), FRAC_BITS);
      nx[6].ln[i].day = icr_pkg::fmul(icr_pkg::sx(st[5].ln[i].pra.y),
                                      icr_pkg::sx(st[5].c.n.y), FRAC_BITS);
      nx[6].ln[i].dbx = icr_pkg::fmul(icr_pkg::sx(st[5].ln[i].prb.x),
                                      icr_pkg::sx(st[5].c.n.x), FRAC_BITS);
      nx[6].ln[i].dby = icr_pkg::fmul(icr_pkg::sx(st[5].ln[i].prb.y),
                                      icr_pkg::sx(st[5].c.n.y), FRAC_BITS);
    end
  end

  // Relative contact velocity and the perpendicular-normal dots.
  always_comb begin
    nx[7] = st[6];
    for (int i = 0; i < icr_pkg::LANES; i++) begin
      nx[7].ln[i].rel.x = icr_pkg::sat32(
        icr_pkg::s64(icr_pkg::sat32(icr_pkg::s64(st[6].c.va.x) + st[6].ln[i].mwax)) -
        icr_pkg::s64(icr_pkg::sat32(icr_pkg::s64(st[6].c.vb.x) + st[6].ln[i].mwbx)));
      nx[7].ln[i].rel.y = icr_pkg::sat32(
        icr_pkg::s64(icr_pkg::sat32(icr_pkg::s64(st[6].c.va.y) + st[6].ln[i].mway)) -
        icr_pkg::s64(icr_pkg::sat32(icr_pkg::s64(st[6].c.vb.y) + st[6].ln[i].mwby)));
      nx[7].ln[i].ran = icr_pkg::sat32(st[6].ln[i].dax + st[6].ln[i].day);
      nx[7].ln[i].rbn = icr_pkg::sat32(st[6].ln[i].dbx + st[6].ln[i].dby);
    end
  end

  always_comb begin
    nx[8] = st[7];
    for (int i = 0; i < icr_pkg::LANES; i++) begin
      nx[8].ln[i].e0 = icr_pkg::fmul(icr_pkg::sx(st[7].ln[i].rel.x),
                                     icr_pkg::sx(st[7].c.n.x), FRAC_BITS);
      nx[8].ln[i].e1 = icr_pkg::fmul(icr_pkg::sx(st[7].ln[i].rel.y),
                                     icr_pkg::sx(st[7].c.n.y), FRAC_BITS);
      nx[8].ln[i].qa = icr_pkg::fmul(icr_pkg::sx(st[7].ln[i].ran),
                                     icr_pkg::sx(st[7].ln[i].ran), FRAC_BITS);
      nx[8].ln[i].qb = icr_pkg::fmul(icr_pkg::sx(st[7].ln[i].rbn),
                                     icr_pkg::sx(st[7].ln[i].rbn), FRAC_BITS);
    end
  end

  always_comb begin
    nx[9] = st[8];
    for (int i = 0; i < icr_pkg::LANES; i++) begin
      nx[9].ln[i].vn  = icr_pkg::sat32(st[8].ln[i].e0 + st[8].ln[i].e1);
      nx[9].ln[i].sqa = icr_pkg::sat32(st[8].ln[i].qa);
      nx[9].ln[i].sqb = icr_pkg::sat32(st[8].ln[i].qb);
    end
  end

  // Restitution-scaled numerator and the rotational terms of the denominator.
  always_comb begin
    logic signed [49:0] cv;
    nx[10] = st[9];
    cv = '0;
    for (int i = 0; i < icr_pkg::LANES; i++) begin
      cv = 50'($signed({1'b0, st[9].coeff})) * 50'(st[9].ln[i].vn);
      nx[10].ln[i].num = icr_pkg::sat32(64'((cv + 50'sd32768) >>> 16));
      nx[10].ln[i].ta = icr_pkg::fmul(icr_pkg::sx(st[9].ln[i].sqa),
                                      icr_pkg::ux(st[9].c.iia), FRAC_BITS);
      nx[10].ln[i].tb = icr_pkg::fmul(icr_pkg::sx(st[9].ln[i].sqb),
                                      icr_pkg::ux(st[9].c.iib), FRAC_BITS);
    end
  end

  // Denominator, doubled for two contacts; sign and magnitude of the numerator; lane activity.
  always_comb begin
    logic [63:0] den;
    nx[11] = st[10];
    den = '0;
    for (int i = 0; i < icr_pkg::LANES; i++) begin
      den = 64'(st[10].c.ima) + 64'(st[10].c.imb) +
            64'(st[10].ln[i].ta) + 64'(st[10].ln[i].tb);
      nx[11].ln[i].dsor = (st[10].c.cnt == 2'd2) ? (den << 1) : den;
      nx[11].ln[i].neg  = st[10].ln[i].num[31];
      nx[11].ln[i].mag  = st[10].ln[i].num[31] ?
                          32'(-icr_pkg::s64(st[10].ln[i].num)) : 32'(st[10].ln[i].num);
      nx[11].ln[i].act  = (i < st[10].c.cnt) && (den != 64'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (ce) begin
      v <= {v[NST-1:1], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int k = 1; k <= NST; k++) begin
        st[k] <= nx[k];
      end
    end
  end

  assign out_valid = v[NST];
  assign out_ctx   = st[NST].c;

  always_comb begin
    for (int i = 0; i < icr_pkg::LANES; i++) begin
      out_lane[i].mag  = st[NST].ln[i].mag;
      out_lane[i].dsor = st[NST].ln[i].dsor;
      out_lane[i].neg  = st[NST].ln[i].neg;
      out_lane[i].act  = st[NST].ln[i].act;
    end
  end

endmodule
`default_nettype wire

// ===== sv/icr_div.sv =====
// Pipelined restoring divider, one quotient bit per stage for every contact lane.
`default_nettype none
module icr_div #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire logic                                    ce,
  input  wire logic                                    in_valid,
  input  wire icr_pkg::ctx_t                           in_ctx,
  input  wire icr_pkg::dv_in_t [icr_pkg::LANES-1:0]    in_lane,
  output logic                                         out_valid,
  output icr_pkg::ctx_t                                out_ctx,
  output icr_pkg::dv_out_t [icr_pkg::LANES-1:0]        out_lane
);

  localparam int QW = 32 + FRAC_BITS;   // dividend and quotient bits
  localparam int DW = 66 - FRAC_BITS;   // divisor bits

  logic [QW-1:0]  dv;
  icr_pkg::ctx_t  dc  [QW];
  logic [DW-1:0]  rem [icr_pkg::LANES][QW];
  logic [QW-1:0]  quo [icr_pkg::LANES][QW];
  logic [DW-1:0]  dd  [icr_pkg::LANES][QW];
  logic           ng  [icr_pkg::LANES][QW];
  logic           ac  [icr_pkg::LANES][QW];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv <= '0;
    end else if (ce) begin
      dv <= {dv[QW-2:0], in_valid};
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_st
    if (k == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (ce) begin
          dc[k] <= in_ctx;
        end
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (ce) begin
          dc[k] <= dc[k-1];
        end
      end
    end

    for (genvar l = 0; l < icr_pkg::LANES; l++) begin : g_ln
      logic [DW-1:0] rp;
      logic [DW-1:0] dp;
      logic [QW-1:0] qp;
      logic          np;
      logic          ap;
      logic [DW:0]   trial;
      logic [DW:0]   diff;
      logic          ge;

      if (k == 0) begin : g_src0
        assign rp = '0;
        assign qp = {in_lane[l].mag, {FRAC_BITS{1'b0}}};
        assign dp = in_lane[l].dsor[DW-1:0];
        assign np = in_lane[l].neg;
        assign ap = in_lane[l].act;
      end else begin : g_srcn
        assign rp = rem[l][k-1];
        assign qp = quo[l][k-1];
        assign dp = dd[l][k-1];
        assign np = ng[l][k-1];
        assign ap = ac[l][k-1];
      end

      assign trial = {rp, qp[QW-1]};
      assign diff  = trial - {1'b0, dp};
      assign ge    = (trial >= {1'b0, dp});

      always_ff @(posedge clk) begin
        if (ce) begin
          rem[l][k] <= ge ? diff[DW-1:0] : trial[DW-1:0];
          quo[l][k] <= {qp[QW-2:0], ge};
          dd[l][k]  <= dp;
          ng[l][k]  <= np;
          ac[l][k]  <= ap;
        end
      end
    end
  end

  assign out_valid = dv[QW-1];
  assign out_ctx   = dc[QW-1];

  always_comb begin
    for (int l = 0; l < icr_pkg::LANES; l++) begin
      out_lane[l].quo = 64'(quo[l][QW-1]);
      out_lane[l].neg = ng[l][QW-1];
      out_lane[l].act = ac[l][QW-1];
    end
  end

endmodule
`default_nettype wire

// ===== sv/icr_back.sv =====
// Impulse vectors, velocity and spin changes, and the output register.
`default_nettype none
module icr_back #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire logic                                    ce,
  input  wire logic                                    in_valid,
  input  wire icr_pkg::ctx_t                           in_ctx,
  input  wire icr_pkg::dv_out_t [icr_pkg::LANES-1:0]   in_lane,
  output logic                                         out_valid,
  output logic [319:0]                                 out_data
);

  localparam int NST = 6;

  typedef struct packed {
    icr_pkg::s32_t      j;
    icr_pkg::vec_t      imp;
    logic signed [63:0] ax;
    logic signed [63:0] ay;
    logic signed [63:0] bx;
    logic signed [63:0] by;
    logic signed [63:0] c1;
    logic signed [63:0] c2;
    logic signed [63:0] c3;
    logic signed [63:0] c4;
    icr_pkg::s32_t      sax;
    icr_pkg::s32_t      say;
    icr_pkg::s32_t      sbx;
    icr_pkg::s32_t      sby;
    icr_pkg::s32_t      cra;
    icr_pkg::s32_t      crb;
    logic signed [63:0] ga;
    logic signed [63:0] gb;
    icr_pkg::s32_t      sga;
    icr_pkg::s32_t      sgb;
  } lane_t;

  typedef struct packed {
    icr_pkg::ctx_t               c;
    lane_t [icr_pkg::LANES-1:0]  ln;
  } bk_t;

  bk_t nx [1:NST];
  bk_t st [1:NST];
  logic [NST+1:1] v;
  logic [319:0] odata_next;

  // Impulse factor; an idle lane carries zero.
  always_comb begin
    logic signed [63:0] q;
    nx[1] = '0;
    nx[1].c = in_ctx;
    q = '0;
    for (int i = 0; i < icr_pkg::LANES; i++) begin
      q = $signed(in_lane[i].quo);
      if (in_lane[i].act) begin
        nx[1].ln[i].j = icr_pkg::sat32(in_lane[i].neg ? q : -q);
      end
    end
  end

  always_comb begin
    nx[2] = st[1];
    for (int i = 0; i < icr_pkg::LANES; i++) begin
      nx[2].ln[i].imp.x = icr_pkg::sat32(icr_pkg::fmul(icr_pkg::sx(st[1].ln[i].j),
                                         icr_pkg::sx(st[1].c.n.x), FRAC_BITS));
      nx[2].ln[i].imp.y = icr_pkg::sat32(icr_pkg::fmul(icr_pkg::sx(st[1].ln[i].j),
                                         icr_pkg::sx(st[1].c.n.y), FRAC_BITS));
    end
  end

  always_comb begin
    nx[3] = st[2];
    for (int i = 0; i < icr_pkg::LANES; i++) begin
      nx[3].ln[i].ax = icr_pkg::fmul(icr_pkg::sx(st[2].ln[i].imp.x),
                                     icr_pkg::ux(st[2].c.ima), FRAC_BITS);
      nx[3].ln[i].ay = icr_pkg::fmul(icr_pkg::sx(st[2].ln[i].imp.y),
                                     icr_pkg::ux(st[2].c.ima), FRAC_BITS);
      nx[3].ln[i].bx = icr_pkg::fmul(icr_pkg::sx(st[2].ln[i].imp.x),
                                     icr_pkg::ux(st[2].c.imb), FRAC_BITS);
      nx[3].ln[i].by = icr_pkg::fmul(icr_pkg::sx(st[2].ln[i].imp.y),
                                     icr_pkg::ux(st[2].c.imb), FRAC_BITS);
      nx[3].ln[i].c1 = icr_pkg::fmul(icr_pkg::sx(st[2].c.ra[i].x),
                                     icr_pkg::sx(st[2].ln[i].imp.y), FRAC_BITS);
      nx[3].ln[i].c2 = icr_pkg::fmul(icr_pkg::sx(st[2].c.ra[i].y),
                                     icr_pkg::sx(st[2].ln[i].imp.x), FRAC_BITS);
      nx[3].ln[i].c3 = icr_pkg::fmul(icr_pkg::sx(st[2].c.rb[i].x),
                                     icr_pkg::sx(st[2].ln[i].imp.y), FRAC_BITS);
      nx[3].ln[i].c4 = icr_pkg::fmul(icr_pkg::sx(st[2].c.rb[i].y),
                                     icr_pkg::sx(st[2].ln[i].imp.x), FRAC_BITS);
    end
  end

  always_comb begin
    nx[4] = st[3];
    for (int i = 0; i < icr_pkg::LANES; i++) begin
      nx[4].ln[i].sax = icr_pkg::sat32(st[3].ln[i].ax);
      nx[4].ln[i].say = icr_pkg::sat32(st[3].ln[i].ay);
      nx[4].ln[i].sbx = icr_pkg::sat32(st[3].ln[i].bx);
      nx[4].ln[i].sby = icr_pkg::sat32(st[3].ln[i].by);
      nx[4].ln[i].cra = icr_pkg::sat32(st[3].ln[i].c1 - st[3].ln[i].c2);
      nx[4].ln[i].crb = icr_pkg::sat32(st[3].ln[i].c3 - st[3].ln[i].c4);
    end
  end

  always_comb begin
    nx[5] = st[4];
    for (int i = 0; i < icr_pkg::LANES; i++) begin
      nx[5].ln[i].ga = icr_pkg::fmul(icr_pkg::sx(st[4].ln[i].cra),
                                     icr_pkg::ux(st[4].c.iia), FRAC_BITS);
      nx[5].ln[i].gb = icr_pkg::fmul(icr_pkg::sx(st[4].ln[i].crb),
                                     icr_pkg::ux(st[4].c.iib), FRAC_BITS);
    end
  end

  always_comb begin
    nx[6] = st[5];
    for (int i = 0; i < icr_pkg::LANES; i++) begin
      nx[6].ln[i].sga = icr_pkg::sat32(st[5].ln[i].ga);
      nx[6].ln[i].sgb = icr_pkg::sat32(st[5].ln[i].gb);
    end
  end

  // Sum the lane changes and apply them.
  always_comb begin
    logic signed [63:0] vax;
    logic signed [63:0] vay;
    logic signed [63:0] vbx;
    logic signed [63:0] vby;
    logic signed [63:0] dwa;
    logic signed [63:0] dwb;
    vax = icr_pkg::s64(st[6].c.va.x);
    vay = icr_pkg::s64(st[6].c.va.y);
    vbx = icr_pkg::s64(st[6].c.vb.x);
    vby = icr_pkg::s64(st[6].c.vb.y);
    dwa = icr_pkg::s64(st[6].c.wa);
    dwb = icr_pkg::s64(st[6].c.wb);
    for (int i = 0; i < icr_pkg::LANES; i++) begin
      vax = vax + icr_pkg::s64(st[6].ln[i].sax);
      vay = vay + icr_pkg::s64(st[6].ln[i].say);
      vbx = vbx - icr_pkg::s64(st[6].ln[i].sbx);
      vby = vby - icr_pkg::s64(st[6].ln[i].sby);
      dwa = dwa + icr_pkg::s64(st[6].ln[i].sga);
      dwb = dwb - icr_pkg::s64(st[6].ln[i].sgb);
    end
    odata_next = {icr_pkg::sat32(dwa), icr_pkg::sat32(dwb),
                  icr_pkg::sat32(vbx), icr_pkg::sat32(vby),
                  icr_pkg::sat32(vax), icr_pkg::sat32(vay),
                  st[6].c.pb, st[6].c.pa};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (ce) begin
      v <= {v[NST:1], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int k = 1; k <= NST; k++) begin
        st[k] <= nx[k];
      end
      out_data <= odata_next;
    end
  end

  assign out_valid = v[NST+1];

endmodule
`default_nettype wire

// ===== sv/impulse_collision_response_unit.sv =====
// Impulse-based 2D collision response: separation, contact impulses, new velocities.
// The divider resolves one quotient bit per stage over 32 + FRAC_BITS stages.
// Throughput is one word per cycle; every stage advances together and holds while
// the output word waits. Reset clears only the valid bits; data registers keep garbage.
`default_nettype none
module impulse_collision_response_unit #(
  parameter int FRAC_BITS    = 16,
  parameter int MAX_CONTACTS = 2
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // position_a, position_b, velocity_a, velocity_b, spins, inverse_masses,
  // inverse_inertias, depth_and_bounce, normal, contact_first, contact_second
  input  wire logic [703:0] s_axis_tdata,
  // mode_bits
  input  wire logic [3:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // new_position_a, new_position_b, new_velocity_a, new_velocity_b, new_spins
  output logic [319:0]      m_axis_tdata
);

  // The whole pipeline moves when the output register is empty or being taken.
  logic ce;

  logic                                  fr_valid;
  icr_pkg::ctx_t                         fr_ctx;
  icr_pkg::dv_in_t [icr_pkg::LANES-1:0]  fr_lane;
  logic                                  dv_valid;
  icr_pkg::ctx_t                         dv_ctx;
  icr_pkg::dv_out_t [icr_pkg::LANES-1:0] dv_lane;

  assign ce            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = ce;

  // Separation and per-contact numerator/denominator.
  icr_front #(
    .FRAC_BITS    (FRAC_BITS),
    .MAX_CONTACTS (MAX_CONTACTS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .in_valid  (s_axis_tvalid),
    .in_data   (s_axis_tdata),
    .in_mode   (s_axis_tuser),
    .out_valid (fr_valid),
    .out_ctx   (fr_ctx),
    .out_lane  (fr_lane)
  );

  // Impulse division for every contact lane.
  icr_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .in_valid  (fr_valid),
    .in_ctx    (fr_ctx),
    .in_lane   (fr_lane),
    .out_valid (dv_valid),
    .out_ctx   (dv_ctx),
    .out_lane  (dv_lane)
  );

  // Impulse application; its last register is the output register.
  icr_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .in_valid  (dv_valid),
    .in_ctx    (dv_ctx),
    .in_lane   (dv_lane),
    .out_valid (m_axis_tvalid),
    .out_data  (m_axis_tdata)
  );

endmodule
`default_nettype wire
